// File: sv/utf2w_pkg.sv
// Shared types and constants for the UTF-8 to wide decoder.
// Used by the front, queue, back and top-level modules and by the checker.
package utf2w_pkg;

  localparam logic [20:0] REPL_CHAR  = 21'h00FFFD;
  localparam logic [20:0] MAX_POINT  = 21'h10FFFF;
  localparam logic [20:0] SURR_FIRST = 21'h00D800;
  localparam logic [20:0] SURR_LAST  = 21'h00DFFF;
  localparam logic [20:0] HI_SURR    = 21'h00D800;
  localparam logic [20:0] LO_SURR    = 21'h00DC00;
  localparam logic [20:0] SUPP_BASE  = 21'h010000;
  localparam logic [20:0] MIN_TWO    = 21'h000080;
  localparam logic [20:0] MIN_THREE  = 21'h000800;

  localparam logic [1:0] NEED_ONE   = 2'd1;
  localparam logic [1:0] NEED_TWO   = 2'd2;
  localparam logic [1:0] NEED_THREE = 2'd3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_word_t;

  typedef struct packed {
    logic [20:0] code_unit;
    logic        last_unit;
  } out_word_t;

  // Code points caused by one input byte: one, or two when two is set.
  typedef struct packed {
    logic [20:0] pt0;
    logic [20:0] pt1;
    logic        two;
  } job_t;

endpackage

// File: sv/utf2w_front.sv
// Front end: accepts bytes, tracks the open UTF-8 sequence and queues code points.
// Depends on utf2w_pkg.
module utf2w_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  utf2w_pkg::in_word_t in_data,
  input  logic              q_full,
  output logic              q_push,
  output utf2w_pkg::job_t   q_job
);
  import utf2w_pkg::*;

  logic [20:0] pp_r, pp_nxt;
  logic [1:0]  exp_r, exp_nxt;
  logic [1:0]  rcv_r, rcv_nxt;

  logic [7:0]  b;
  logic        eos;
  logic        accept;
  logic        cont;
  logic        f_emit;
  logic        f_open;
  logic [20:0] f_pt;
  logic [20:0] f_pp;
  logic [1:0]  f_exp;
  logic [20:0] pp_c;
  logic [1:0]  rcv_c;
  logic        bad;
  logic        emit_any;

  assign b        = in_data.in_byte;
  assign eos      = in_data.end_of_string;
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign cont     = (b[7:6] == 2'b10);
  assign pp_c     = {pp_r[14:0], b[5:0]};
  assign rcv_c    = rcv_r + 2'd1;

  always_comb begin
    f_emit = 1'b0;
    f_open = 1'b0;
    f_pt   = REPL_CHAR;
    f_pp   = '0;
    f_exp  = '0;
    if (!b[7]) begin
      f_emit = 1'b1;
      f_pt   = {13'd0, b};
    end else if (b[7:5] == 3'b110) begin
      f_open = 1'b1;
      f_exp  = NEED_ONE;
      f_pp   = {16'd0, b[4:0]};
    end else if (b[7:4] == 4'b1110) begin
      f_open = 1'b1;
      f_exp  = NEED_TWO;
      f_pp   = {17'd0, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      f_open = 1'b1;
      f_exp  = NEED_THREE;
      f_pp   = {18'd0, b[2:0]};
    end else begin
      f_emit = 1'b1;
    end
    if (f_open && eos) begin
      f_open = 1'b0;
      f_emit = 1'b1;
      f_pt   = REPL_CHAR;
    end
  end

  always_comb begin
    bad = ((exp_r == NEED_ONE) && (pp_c < MIN_TWO)) ||
          ((exp_r == NEED_TWO) && (pp_c < MIN_THREE)) ||
          ((exp_r == NEED_THREE) && (pp_c < SUPP_BASE)) ||
          (pp_c > MAX_POINT) ||
          ((pp_c >= SURR_FIRST) && (pp_c <= SURR_LAST));
  end

  always_comb begin
    pp_nxt    = pp_r;
    exp_nxt   = exp_r;
    rcv_nxt   = rcv_r;
    emit_any  = 1'b0;
    q_job.pt0 = REPL_CHAR;
    q_job.pt1 = f_pt;
    q_job.two = 1'b0;
    if ((exp_r != 2'd0) && cont) begin
      if (rcv_c >= exp_r) begin
        emit_any  = 1'b1;
        q_job.pt0 = bad ? REPL_CHAR : pp_c;
        pp_nxt    = '0;
        exp_nxt   = '0;
        rcv_nxt   = '0;
      end else if (eos) begin
        emit_any = 1'b1;
        pp_nxt   = '0;
        exp_nxt  = '0;
        rcv_nxt  = '0;
      end else begin
        pp_nxt  = pp_c;
        rcv_nxt = rcv_c;
      end
    end else begin
      if (exp_r != 2'd0) begin
        emit_any  = 1'b1;
        q_job.two = f_emit;
      end else begin
        emit_any  = f_emit;
        q_job.pt0 = f_pt;
      end
      pp_nxt  = f_open ? f_pp : '0;
      exp_nxt = f_open ? f_exp : '0;
      rcv_nxt = '0;
    end
  end

  assign q_push = accept && emit_any;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pp_r  <= '0;
      exp_r <= '0;
      rcv_r <= '0;
    end else if (accept) begin
      pp_r  <= pp_nxt;
      exp_r <= exp_nxt;
      rcv_r <= rcv_nxt;
    end
  end

endmodule

// File: sv/utf2w_queue.sv
// Short job queue between the front end and the back end.
// Depends on utf2w_pkg for the job type and depth.
module utf2w_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  utf2w_pkg::job_t push_job,
  input  logic            pop,
  output utf2w_pkg::job_t head,
  output logic            empty,
  output logic            full
);
  import utf2w_pkg::*;

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// File: sv/utf2w_back.sv
// Back end: turns queued code points into output words, splitting into surrogates.
// Depends on utf2w_pkg.
module utf2w_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 utf16_mode,
  input  utf2w_pkg::job_t      head,
  input  logic                 q_empty,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output utf2w_pkg::out_word_t out_data
);
  import utf2w_pkg::*;

  logic      out_valid_r, out_valid_nxt;
  out_word_t out_data_r, out_data_nxt;
  logic      phase_r, phase_nxt;

  logic        load;
  logic        split;
  logic        second;
  logic [20:0] v;
  logic [20:0] hi_unit;
  logic [20:0] lo_unit;

  assign load    = !q_empty && (!out_valid_r || out_ready);
  assign split   = utf16_mode && (head.pt0[20:16] != 5'd0);
  assign second  = head.two || split;
  assign v       = head.pt0 - SUPP_BASE;
  assign hi_unit = HI_SURR | {11'd0, v[19:10]};
  assign lo_unit = LO_SURR | {11'd0, v[9:0]};

  always_comb begin
    out_data_nxt  = out_data_r;
    phase_nxt     = phase_r;
    q_pop         = 1'b0;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      if (!phase_r) begin
        out_data_nxt.code_unit = split ? hi_unit : head.pt0;
        out_data_nxt.last_unit = !second;
        q_pop                  = !second;
        phase_nxt              = second;
      end else begin
        out_data_nxt.code_unit = head.two ? head.pt1 : lo_unit;
        out_data_nxt.last_unit = 1'b1;
        q_pop                  = 1'b1;
        phase_nxt              = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: sv/utf8_to_wide_decoder_unit.sv
// Top level of the UTF-8 to wide decoder: mode register, front end, queue and back end.
// Depends on utf2w_pkg, utf2w_front, utf2w_queue and utf2w_back.
//
// The decoder takes one UTF-8 byte per word and can accept a new byte in every cycle
// while its two-entry job queue has room. A byte gives zero, one or two output words;
// the output register hands out one word per cycle while out_ready is high, so bytes
// giving two words (a surrogate pair in UTF-16 mode, or a replacement followed by the
// breaking byte) hold the output for both. Results pass the job queue, then the output
// register. The mode register should be written only while no words are in flight.
module utf8_to_wide_decoder_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  utf2w_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output utf2w_pkg::out_word_t out_data,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data
);
  import utf2w_pkg::*;

  logic utf16_output_r;
  logic q_push;
  logic q_pop;
  logic q_empty;
  logic q_full;
  job_t q_job;
  job_t q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      utf16_output_r <= 1'b0;
    end else if (cfg_wr_en) begin
      utf16_output_r <= cfg_wr_data;
    end
  end

  utf2w_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (q_job)
  );

  utf2w_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  utf2w_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .utf16_mode (utf16_output_r),
    .head       (q_head),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// File: sv/utf2w_checker.sv
// Port-level checks for the UTF-8 to wide decoder, bound to the top level.
// Depends on utf2w_pkg and utf8_to_wide_decoder_unit.
module utf2w_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input utf2w_pkg::out_word_t out_data
);
  import utf2w_pkg::*;

  logic is_hi;
  logic is_lo;

  assign is_hi = (out_data.code_unit[20:10] == HI_SURR[20:10]);
  assign is_lo = (out_data.code_unit[20:10] == LO_SURR[20:10]);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_unit |-> is_hi || (out_data.code_unit == REPL_CHAR))
    else $error("unexpected non-final word");

  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && is_hi && !out_data.last_unit |=>
      out_valid && is_lo && out_data.last_unit)
    else $error("high surrogate not followed by low surrogate");

endmodule

bind utf8_to_wide_decoder_unit utf2w_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// File: tb/utf8_to_wide_decoder_check.sv
// Watches the byte and code-unit channels of the UTF-8 to wide decoder, predicts each output
// word from the accepted bytes and the mode register, and counts mismatches.
// Depends on utf2w_pkg for the word types and code-point constants.
module utf8_to_wide_decoder_check (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  utf2w_pkg::in_word_t  in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  utf2w_pkg::out_word_t out_data,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data,
  output int                   error_count,
  output int                   words_pending
);
  import utf2w_pkg::*;

  localparam logic [20:0] LOW_TEN_BITS = 21'h0003FF;
  localparam int          REPORT_LIMIT = 10;

  logic        utf16_mode = 1'b0;
  logic [20:0] seq_point  = '0;
  logic [1:0]  seq_need   = '0;
  logic [1:0]  seq_got    = '0;
  out_word_t   unit_q[$];
  int          err_n      = 0;

  task automatic log_error(input string msg);
    err_n++;
    if (err_n <= REPORT_LIMIT) begin
      $display("[%0t] decode error: %s", $realtime, msg);
    end
  endtask

  task automatic close_seq();
    seq_point = '0;
    seq_need  = '0;
    seq_got   = '0;
  endtask

  task automatic add_unit(input out_word_t w);
    unit_q.insert(unit_q.size(), w);
  endtask

  task automatic push_point(input logic [20:0] cp);
    logic [20:0] offs;
    offs = cp - SUPP_BASE;
    if (utf16_mode && cp >= SUPP_BASE && cp <= MAX_POINT) begin
      add_unit(out_word_t'{code_unit: HI_SURR | (offs >> 10), last_unit: 1'b0});
      add_unit(out_word_t'{code_unit: LO_SURR | (offs & LOW_TEN_BITS), last_unit: 1'b0});
    end else begin
      add_unit(out_word_t'{code_unit: cp, last_unit: 1'b0});
    end
  endtask

  task automatic start_byte(input logic [7:0] b, input logic eos);
    if (b[7] == 1'b0) begin
      push_point({13'd0, b});
      return;
    end else if (b[7:5] == 3'b110) begin
      seq_point = {16'd0, b[4:0]};
      seq_need  = NEED_ONE;
    end else if (b[7:4] == 4'b1110) begin
      seq_point = {17'd0, b[3:0]};
      seq_need  = NEED_TWO;
    end else if (b[7:3] == 5'b11110) begin
      seq_point = {18'd0, b[2:0]};
      seq_need  = NEED_THREE;
    end else begin
      push_point(REPL_CHAR);
      return;
    end
    seq_got = '0;
    if (eos) begin
      close_seq();
      push_point(REPL_CHAR);
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic eos);
    int          first;
    logic [20:0] cp;
    out_word_t   tail;
    first = unit_q.size();
    if (seq_need != '0) begin
      if (b[7:6] == 2'b10) begin
        seq_point = {seq_point[14:0], b[5:0]};
        seq_got   = seq_got + 2'd1;
        if (seq_got >= seq_need) begin
          cp = seq_point;
          if ((seq_need == NEED_ONE && cp < MIN_TWO) ||
              (seq_need == NEED_TWO && cp < MIN_THREE) ||
              (seq_need == NEED_THREE && cp < SUPP_BASE) ||
              cp > MAX_POINT || (cp >= SURR_FIRST && cp <= SURR_LAST)) begin
            cp = REPL_CHAR;
          end
          close_seq();
          push_point(cp);
        end else if (eos) begin
          close_seq();
          push_point(REPL_CHAR);
        end
      end else begin
        close_seq();
        push_point(REPL_CHAR);
        start_byte(b, eos);
      end
    end else begin
      start_byte(b, eos);
    end
    if (unit_q.size() > first) begin
      tail = unit_q[unit_q.size() - 1];
      tail.last_unit = 1'b1;
      unit_q[unit_q.size() - 1] = tail;
    end
  endtask

  always @(posedge clk) begin : watch_proc
    out_word_t head;
    if (!rst_n) begin
      utf16_mode = 1'b0;
      close_seq();
      unit_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (unit_q.size() == 0) begin
          log_error($sformatf("unexpected word: code_unit %h last_unit %b",
                              out_data.code_unit, out_data.last_unit));
        end else begin
          head = unit_q.pop_front();
          if (out_data.code_unit !== head.code_unit) begin
            log_error($sformatf("code_unit expected %h, got %h",
                                head.code_unit, out_data.code_unit));
          end
          if (out_data.last_unit !== head.last_unit) begin
            log_error($sformatf("last_unit expected %b, got %b (code_unit %h)",
                                head.last_unit, out_data.last_unit, head.code_unit));
          end
        end
      end
      if (in_valid && in_ready) begin
        decode_byte(in_data.in_byte, in_data.end_of_string);
      end
      if (cfg_wr_en) begin
        utf16_mode = cfg_wr_data;
      end
    end
    error_count   <= err_n;
    words_pending <= unit_q.size();
  end

endmodule

// File: tb/utf8_to_wide_decoder_unit_tb.sv
// Top of the UTF-8 to wide decoder testbench: clock, reset, byte stimulus, output stalls and
// mode register writes. Depends on utf2w_pkg, utf8_to_wide_decoder_unit and
// utf8_to_wide_decoder_check, which does all prediction and comparison.
module utf8_to_wide_decoder_unit_tb;
  import utf2w_pkg::*;

  localparam int RANDOM_BYTES  = 450;
  localparam int PHASES        = 8;
  localparam int HOLD_CYCLES   = 60;
  localparam int SETTLE_CYCLES = 8;
  localparam int RESET_CYCLES  = 11;
  localparam int SEND_IDLE [4] = '{0, 74, 0, 36};
  localparam int RECV_STALL[4] = '{0, 0, 74, 36};
  localparam logic [20:0] EDGE_POINTS[10] = '{21'h000000, 21'h00007F, 21'h000080, 21'h0007FF,
                                               21'h000800, 21'h00D7FF, 21'h00E000, 21'h00FFFF,
                                               21'h010000, 21'h10FFFF};
  // Bit 8 marks the last byte of a string.
  localparam logic [8:0] DIRECTED[25] = '{
    9'h000, 9'h17F,
    9'h0C2, 9'h080,
    9'h0ED, 9'h0A0, 9'h080,
    9'h0F0, 9'h09F, 9'h098, 9'h080,
    9'h0F4, 9'h090, 9'h080, 9'h080,
    9'h0C1, 9'h0BF,
    9'h080,
    9'h0FF,
    9'h0E2, 9'h041,
    9'h0E2, 9'h182,
    9'h0E2, 9'h1C3
  };

  logic      clk         = 1'b0;
  logic      rst_n       = 1'b0;
  logic      in_valid    = 1'b0;
  logic      in_ready;
  in_word_t  in_data     = '0;
  logic      out_valid;
  logic      out_ready   = 1'b1;
  out_word_t out_data;
  logic      cfg_wr_en   = 1'b0;
  logic      cfg_wr_data = 1'b0;
  int        error_count;
  int        words_pending;

  int         send_idle_pct  = 0;
  int         recv_stall_pct = 0;
  logic       hold_toggle    = 1'b0;
  logic       hold_seen      = 1'b0;
  int         hold_left      = 0;
  logic [7:0] seq_q[$];

  always #2 clk = ~clk;

  utf8_to_wide_decoder_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  utf8_to_wide_decoder_check decode_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .error_count  (error_count),
    .words_pending(words_pending)
  );

  // A toggle of hold_toggle starts a long hold-off, during which the decoder fills up.
  always @(posedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eos);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= in_word_t'{in_byte: b, end_of_string: eos};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic utf16);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= utf16;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic add_byte(input logic [7:0] b);
    seq_q.insert(seq_q.size(), b);
  endtask

  task automatic encode_point(input logic [20:0] cp, input int len);
    seq_q.delete();
    case (len)
      1: add_byte({1'b0, cp[6:0]});
      2: begin
        add_byte({3'b110, cp[10:6]});
        add_byte({2'b10, cp[5:0]});
      end
      3: begin
        add_byte({4'b1110, cp[15:12]});
        add_byte({2'b10, cp[11:6]});
        add_byte({2'b10, cp[5:0]});
      end
      default: begin
        add_byte({5'b11110, cp[20:18]});
        add_byte({2'b10, cp[17:12]});
        add_byte({2'b10, cp[11:6]});
        add_byte({2'b10, cp[5:0]});
      end
    endcase
  endtask

  initial begin : stimulus
    int          sent;
    int          kind;
    int          len;
    logic [20:0] cp;
    logic        eos;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_mode(1'b1);
    foreach (DIRECTED[i]) send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);

    for (int ph = 0; ph < PHASES; ph++) begin
      write_mode(ph[0]);
      send_idle_pct  <= SEND_IDLE[ph / 2];
      recv_stall_pct <= RECV_STALL[ph / 2];
      if (ph == 0) begin
        hold_toggle <= ~hold_toggle;
      end
      sent = 0;
      while (sent < RANDOM_BYTES / PHASES) begin
        kind = $urandom_range(99);
        len  = $urandom_range(1, 4);
        case (len)
          1:       cp = 21'($urandom_range(21'h00007F, 21'h000000));
          2:       cp = 21'($urandom_range(21'h0007FF, 21'h000080));
          3:       cp = 21'($urandom_range(21'h00FFFF, 21'h000800));
          default: cp = 21'($urandom_range(21'h10FFFF, 21'h010000));
        endcase
        eos = ($urandom_range(7) == 0);
        if (kind >= 40 && kind < 50) begin
          cp  = EDGE_POINTS[$urandom_range(9)];
          len = (cp < 21'h80) ? 1 : (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4;
        end else if (kind >= 50 && kind < 70) begin
          // Raw payload bits give overlong forms, surrogates and points above the range.
          cp  = 21'($urandom());
          len = $urandom_range(2, 4);
        end else if (kind >= 70 && kind < 85 && len == 1) begin
          len = $urandom_range(2, 4);
          cp  = 21'($urandom());
        end
        encode_point(cp, len);
        if (kind >= 70 && kind < 85) begin
          repeat ($urandom_range(len - 1, 1)) void'(seq_q.pop_back());
          eos = 1'($urandom_range(1));
        end else if (kind >= 85) begin
          seq_q.delete();
          add_byte(8'($urandom_range(255)));
          eos = ($urandom_range(3) == 0);
        end
        foreach (seq_q[i]) send_byte(seq_q[i], (i == seq_q.size() - 1) && eos);
        sent += seq_q.size();
      end
    end

    wait_idle();
    if (error_count == 0 && words_pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #400000;
    $display("simulation failed");
    $finish;
  end

endmodule
